// File: src/edge_midpoint_triangle_subdivider_assert.svh
// Assertion macros shared by the subdivider RTL.
// Included by modules that check their own sequencing; no other dependencies.
`ifndef EDGE_MIDPOINT_TRIANGLE_SUBDIVIDER_ASSERT_SVH
`define EDGE_MIDPOINT_TRIANGLE_SUBDIVIDER_ASSERT_SVH
`ifndef SYNTHESIS
`define EMTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define EMTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define EMTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define EMTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/emts_pkg.sv
// Types, codes and constants for the edge midpoint triangle subdivider.
// No dependencies; imported by the subdivider and by emts_arith.
`timescale 1ns / 1ps

package emts_pkg;

    localparam int DEF_VERTEX_DEPTH = 4096;
    localparam int DEF_EDGE_SLOTS   = 16384;
    localparam int DEF_PROBE_LIMIT  = 16;
    localparam int DEF_COORD_BITS   = 16;

    localparam int IDX_W    = 12;
    localparam int PORT_CW  = 16;
    localparam int ARITH_W  = 64;
    localparam int STEP_W   = 7;
    localparam int HASH_SHIFT = 32;
    localparam logic [ARITH_W-1:0] HASH_MULT = 64'h9E37_79B9_7F4A_7C15;

    localparam logic [2:0] KIND_LOAD      = 3'd0;
    localparam logic [2:0] KIND_SUBDIVIDE = 3'd1;
    localparam logic [2:0] KIND_READ      = 3'd2;
    localparam logic [2:0] KIND_CLR_EDGES = 3'd3;
    localparam logic [2:0] KIND_CLR_ALL   = 3'd4;

    typedef enum logic [1:0] {
        RK_ACK    = 2'd0,
        RK_VERTEX = 2'd1,
        RK_TRI    = 2'd2,
        RK_READ   = 2'd3
    } t_rkind;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_STORE_FULL = 3'd1,
        STS_TABLE_FULL = 3'd2,
        STS_BAD_INDEX  = 3'd3,
        STS_ZERO_LEN   = 3'd4
    } t_status;

    typedef struct packed {
        t_rkind             kind;
        logic [IDX_W-1:0]   ia;
        logic [IDX_W-1:0]   ib;
        logic [IDX_W-1:0]   ic;
        logic [PORT_CW-1:0] x;
        logic [PORT_CW-1:0] y;
        logic [PORT_CW-1:0] z;
        t_status            status;
        logic               last;
    } t_result;

    typedef enum logic [1:0] {
        AOP_MUL  = 2'd0,
        AOP_SQRT = 2'd1,
        AOP_DIV  = 2'd2
    } t_arith_op;

    typedef struct packed {
        logic               start;
        t_arith_op          op;
        logic [STEP_W-1:0]  steps;
        logic [ARITH_W-1:0] acc;
        logic [ARITH_W-1:0] a;
        logic [ARITH_W-1:0] b;
    } t_arith_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ARITH_W-1:0] result;
    } t_arith_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_EMIT,
        S_RD_WAIT,
        S_EDGE,
        S_HASH,
        S_PRB_RD,
        S_PRB_CHK,
        S_RD_P,
        S_RD_Q,
        S_SQ_GO,
        S_NORM,
        S_WRITE,
        S_TRI
    } t_state;

endpackage

// File: src/edge_midpoint_triangle_subdivider.sv
// Edge midpoint triangle subdivider: vertex store, hashed edge table and one
// sequencer over a shared iterative arithmetic unit (multiply, square root,
// divide), one item at a time. A subdivide hashes each edge and probes the
// edge table; each newly created midpoint then takes three squares, a root and
// three divides. After reset, and for each clear item, the edge table is swept
// one slot a cycle with the input not ready. Depends on emts_pkg, emts_ram,
// emts_arith and the assert header.
`timescale 1ns / 1ps
`include "edge_midpoint_triangle_subdivider_assert.svh"

module edge_midpoint_triangle_subdivider #(
    parameter int VERTEX_DEPTH = emts_pkg::DEF_VERTEX_DEPTH,
    parameter int EDGE_SLOTS   = emts_pkg::DEF_EDGE_SLOTS,
    parameter int PROBE_LIMIT  = emts_pkg::DEF_PROBE_LIMIT,
    parameter int COORD_BITS   = emts_pkg::DEF_COORD_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // index_a[11:0], index_b[23:12], index_c[35:24], coord_x[51:36],
    // coord_y[67:52], coord_z[83:68], zero pad[87:84]
    input  logic [87:0] s_axis_tdata,
    // kind[2:0]
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // out_index_a[11:0], out_index_b[23:12], out_index_c[35:24], out_x[51:36],
    // out_y[67:52], out_z[83:68], status[86:84], zero pad[87]
    output logic [87:0] m_axis_tdata,
    // result_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    import emts_pkg::*;

    localparam int VIDX = $clog2(VERTEX_DEPTH);
    localparam int EB   = $clog2(EDGE_SLOTS);
    localparam int KW   = 2 * VIDX;
    localparam int PW   = $clog2(PROBE_LIMIT + 1);
    localparam int CB   = COORD_BITS;
    localparam int VW   = 3 * CB;
    localparam int EWD  = 1 + KW + VIDX;
    localparam int DSTEPS = 2 * CB - 2;

    // input fields
    logic [IDX_W-1:0]   in_ia, in_ib, in_ic;
    logic [PORT_CW-1:0] in_x, in_y, in_z;
    logic [2:0]         in_kind;
    logic               in_xfer;

    assign in_ia   = s_axis_tdata[11:0];
    assign in_ib   = s_axis_tdata[23:12];
    assign in_ic   = s_axis_tdata[35:24];
    assign in_x    = s_axis_tdata[51:36];
    assign in_y    = s_axis_tdata[67:52];
    assign in_z    = s_axis_tdata[83:68];
    assign in_kind = s_axis_tuser;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    t_state              r_state, n_state;
    t_state              r_after, n_after;
    t_result             r_res, n_res;
    t_result             r_out;
    logic                r_ovalid;
    logic [VIDX:0]       r_cnt, n_cnt;
    logic [IDX_W-1:0]    r_ia, n_ia, r_ib, n_ib, r_ic, n_ic;
    logic [1:0]          r_e, n_e;
    logic [VIDX-1:0]     r_mid [3];
    logic [VIDX-1:0]     n_mid [3];
    logic [EB-1:0]       r_home, n_home;
    logic [PW-1:0]       r_probe, n_probe;
    logic [EB-1:0]       r_slot, n_slot;
    logic [VW-1:0]       r_pd, n_pd;
    logic [CB-1:0]       r_mx, n_mx, r_my, n_my, r_mz, n_mz;
    logic [CB-1:0]       r_s, n_s;
    logic [CB-1:0]       r_nx, n_nx, r_ny, n_ny, r_nz, n_nz;
    logic [2:0]          r_ph, n_ph;
    logic [1:0]          r_t, n_t;
    logic [EB-1:0]       r_clr, n_clr;
    logic                r_clr_ack, n_clr_ack;

    logic                slot_free;
    logic                emit_go;

    logic                vtx_we;
    logic [VIDX-1:0]     vtx_waddr, vtx_raddr;
    logic [VW-1:0]       vtx_wdata, vtx_rdata;
    logic                edge_we;
    logic [EB-1:0]       edge_waddr, edge_raddr;
    logic [EWD-1:0]      edge_wdata, edge_rdata;

    t_arith_req          arith_req;
    t_arith_rsp          arith_rsp;

    logic [VIDX-1:0]     cur_p, cur_q, key_lo, key_hi;
    logic [KW-1:0]       cur_key;
    logic [CB:0]         sum_x, sum_y, sum_z;
    logic [CB-1:0]       mag_x, mag_y, mag_z;
    logic [CB-1:0]       quot, quot_neg;
    logic                store_full;
    logic                bad_tri;

    function automatic t_result make_ack(input t_status st);
        t_result r;
        r        = '0;
        r.kind   = RK_ACK;
        r.status = st;
        r.last   = 1'b1;
        return r;
    endfunction

    emts_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (vtx_we),
        .i_waddr (vtx_waddr),
        .i_wdata (vtx_wdata),
        .i_raddr (vtx_raddr),
        .o_rdata (vtx_rdata)
    );

    emts_ram #(.WIDTH(EWD), .DEPTH(EDGE_SLOTS)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    emts_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arith_req),
        .o_rsp   (arith_rsp)
    );

    assign slot_free  = !r_ovalid || m_axis_tready;
    assign emit_go    = (r_state == S_EMIT) && slot_free;
    assign store_full = 32'(r_cnt) >= VERTEX_DEPTH;
    assign bad_tri    = (32'(in_ia) >= 32'(r_cnt)) || (32'(in_ib) >= 32'(r_cnt))
                        || (32'(in_ic) >= 32'(r_cnt));

    // corners of the edge under work
    always_comb begin
        unique case (r_e)
            2'd1: begin
                cur_p = VIDX'(r_ib);
                cur_q = VIDX'(r_ic);
            end
            2'd2: begin
                cur_p = VIDX'(r_ic);
                cur_q = VIDX'(r_ia);
            end
            default: begin
                cur_p = VIDX'(r_ia);
                cur_q = VIDX'(r_ib);
            end
        endcase
    end

    assign key_lo  = (cur_p < cur_q) ? cur_p : cur_q;
    assign key_hi  = (cur_p < cur_q) ? cur_q : cur_p;
    assign cur_key = {key_lo, key_hi};

    assign sum_x = {r_pd[CB-1], r_pd[CB-1:0]} + {vtx_rdata[CB-1], vtx_rdata[CB-1:0]};
    assign sum_y = {r_pd[2*CB-1], r_pd[2*CB-1:CB]}
                   + {vtx_rdata[2*CB-1], vtx_rdata[2*CB-1:CB]};
    assign sum_z = {r_pd[3*CB-1], r_pd[3*CB-1:2*CB]}
                   + {vtx_rdata[3*CB-1], vtx_rdata[3*CB-1:2*CB]};

    assign mag_x = r_mx[CB-1] ? (~r_mx + 1'b1) : r_mx;
    assign mag_y = r_my[CB-1] ? (~r_my + 1'b1) : r_my;
    assign mag_z = r_mz[CB-1] ? (~r_mz + 1'b1) : r_mz;

    assign quot     = arith_rsp.result[CB-1:0];
    assign quot_neg = ~quot + 1'b1;

    always_comb begin
        n_state   = r_state;
        n_after   = r_after;
        n_res     = r_res;
        n_cnt     = r_cnt;
        n_ia      = r_ia;
        n_ib      = r_ib;
        n_ic      = r_ic;
        n_e       = r_e;
        n_mid     = r_mid;
        n_home    = r_home;
        n_probe   = r_probe;
        n_slot    = r_slot;
        n_pd      = r_pd;
        n_mx      = r_mx;
        n_my      = r_my;
        n_mz      = r_mz;
        n_s       = r_s;
        n_nx      = r_nx;
        n_ny      = r_ny;
        n_nz      = r_nz;
        n_ph      = r_ph;
        n_t       = r_t;
        n_clr     = r_clr;
        n_clr_ack = r_clr_ack;

        s_axis_tready = (r_state == S_IDLE);

        vtx_we     = 1'b0;
        vtx_waddr  = r_cnt[VIDX-1:0];
        vtx_wdata  = {r_nz, r_ny, r_nx};
        vtx_raddr  = cur_p;
        edge_we    = 1'b0;
        edge_waddr = r_slot;
        edge_wdata = {1'b1, cur_key, r_cnt[VIDX-1:0]};
        edge_raddr = EB'(r_home + EB'(r_probe));

        arith_req       = '0;
        arith_req.op    = AOP_MUL;

        unique case (r_state)
            S_CLEAR: begin
                edge_we    = 1'b1;
                edge_waddr = r_clr;
                edge_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (32'(r_clr) == EDGE_SLOTS - 1) begin
                    n_clr = '0;
                    if (r_clr_ack) begin
                        n_res   = make_ack(STS_OK);
                        n_after = S_IDLE;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                vtx_raddr = VIDX'(in_ia);
                vtx_wdata = {CB'(in_z), CB'(in_y), CB'(in_x)};
                if (in_xfer) begin
                    n_ia    = in_ia;
                    n_ib    = in_ib;
                    n_ic    = in_ic;
                    n_after = S_IDLE;
                    n_state = S_EMIT;
                    n_res   = make_ack(STS_OK);
                    priority if (in_kind == KIND_LOAD) begin
                        if (store_full) begin
                            n_res = make_ack(STS_STORE_FULL);
                        end else begin
                            vtx_we   = 1'b1;
                            n_cnt    = r_cnt + 1'b1;
                            n_res.ia = IDX_W'(r_cnt);
                        end
                    end else if (in_kind == KIND_SUBDIVIDE) begin
                        if (bad_tri) begin
                            n_res = make_ack(STS_BAD_INDEX);
                        end else begin
                            n_e     = 2'd0;
                            n_state = S_EDGE;
                        end
                    end else if (in_kind == KIND_READ) begin
                        n_res.kind = RK_READ;
                        n_res.ia   = in_ia;
                        if (32'(in_ia) >= 32'(r_cnt)) begin
                            n_res.status = STS_BAD_INDEX;
                        end else begin
                            n_state = S_RD_WAIT;
                        end
                    end else if (in_kind == KIND_CLR_EDGES || in_kind == KIND_CLR_ALL) begin
                        if (in_kind == KIND_CLR_ALL) begin
                            n_cnt = '0;
                        end
                        n_clr     = '0;
                        n_clr_ack = 1'b1;
                        n_state   = S_CLEAR;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_EMIT: begin
                if (slot_free) begin
                    n_state = r_after;
                end
            end
            S_RD_WAIT: begin
                n_res.x = PORT_CW'(vtx_rdata[CB-1:0]);
                n_res.y = PORT_CW'(vtx_rdata[2*CB-1:CB]);
                n_res.z = PORT_CW'(vtx_rdata[3*CB-1:2*CB]);
                n_state = S_EMIT;
            end
            S_EDGE: begin
                if (r_e == 2'd3) begin
                    n_t     = 2'd0;
                    n_state = S_TRI;
                end else begin
                    arith_req.start = 1'b1;
                    arith_req.op    = AOP_MUL;
                    arith_req.steps = STEP_W'(KW);
                    arith_req.acc   = '0;
                    arith_req.a     = HASH_MULT;
                    arith_req.b     = ARITH_W'(cur_key);
                    n_state         = S_HASH;
                end
            end
            S_HASH: begin
                if (arith_rsp.done) begin
                    n_home  = arith_rsp.result[HASH_SHIFT+EB-1:HASH_SHIFT];
                    n_probe = '0;
                    n_state = S_PRB_RD;
                end
            end
            S_PRB_RD: begin
                n_slot  = edge_raddr;
                n_state = S_PRB_CHK;
            end
            S_PRB_CHK: begin
                // read corner p speculatively for the midpoint path
                vtx_raddr = cur_p;
                if (!edge_rdata[EWD-1]) begin
                    if (store_full) begin
                        n_res   = make_ack(STS_STORE_FULL);
                        n_after = S_IDLE;
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_RD_P;
                    end
                end else if (edge_rdata[VIDX+KW-1:VIDX] == cur_key) begin
                    n_mid[r_e] = edge_rdata[VIDX-1:0];
                    n_e        = r_e + 1'b1;
                    n_state    = S_EDGE;
                end else if (r_probe == PW'(PROBE_LIMIT - 1)) begin
                    n_res   = make_ack(STS_TABLE_FULL);
                    n_after = S_IDLE;
                    n_state = S_EMIT;
                end else begin
                    n_probe = r_probe + 1'b1;
                    n_state = S_PRB_RD;
                end
            end
            S_RD_P: begin
                vtx_raddr = cur_q;
                n_pd      = vtx_rdata;
                n_state   = S_RD_Q;
            end
            S_RD_Q: begin
                n_mx    = sum_x[CB:1];
                n_my    = sum_y[CB:1];
                n_mz    = sum_z[CB:1];
                n_state = S_SQ_GO;
            end
            S_SQ_GO: begin
                arith_req.start = 1'b1;
                arith_req.op    = AOP_MUL;
                arith_req.steps = STEP_W'(CB);
                arith_req.acc   = '0;
                arith_req.a     = ARITH_W'(mag_x);
                arith_req.b     = ARITH_W'(mag_x);
                n_ph            = 3'd0;
                n_state         = S_NORM;
            end
            S_NORM: begin
                if (arith_rsp.done) begin
                    n_ph = r_ph + 1'b1;
                    unique case (r_ph)
                        3'd0, 3'd1: begin
                            arith_req.start = 1'b1;
                            arith_req.op    = AOP_MUL;
                            arith_req.steps = STEP_W'(CB);
                            arith_req.acc   = arith_rsp.result;
                            arith_req.a     = (r_ph == 3'd0) ? ARITH_W'(mag_y)
                                                             : ARITH_W'(mag_z);
                            arith_req.b     = arith_req.a;
                        end
                        3'd2: begin
                            arith_req.start = 1'b1;
                            arith_req.op    = AOP_SQRT;
                            arith_req.steps = STEP_W'(ARITH_W / 2);
                            arith_req.acc   = arith_rsp.result;
                            arith_req.a     = '0;
                            arith_req.b     = ARITH_W'(1) << (ARITH_W - 2);
                        end
                        3'd3: begin
                            if (arith_rsp.result == '0) begin
                                n_res   = make_ack(STS_ZERO_LEN);
                                n_after = S_IDLE;
                                n_state = S_EMIT;
                            end else begin
                                n_s             = arith_rsp.result[CB-1:0];
                                arith_req.start = 1'b1;
                                arith_req.op    = AOP_DIV;
                                arith_req.steps = STEP_W'(DSTEPS);
                                arith_req.acc   = '0;
                                arith_req.a     = ARITH_W'(mag_x) << (ARITH_W - CB);
                                arith_req.b     = arith_rsp.result;
                            end
                        end
                        3'd4, 3'd5: begin
                            if (r_ph == 3'd4) begin
                                n_nx = r_mx[CB-1] ? quot_neg : quot;
                            end else begin
                                n_ny = r_my[CB-1] ? quot_neg : quot;
                            end
                            arith_req.start = 1'b1;
                            arith_req.op    = AOP_DIV;
                            arith_req.steps = STEP_W'(DSTEPS);
                            arith_req.acc   = '0;
                            arith_req.a     = ((r_ph == 3'd4) ? ARITH_W'(mag_y)
                                                              : ARITH_W'(mag_z))
                                              << (ARITH_W - CB);
                            arith_req.b     = ARITH_W'(r_s);
                        end
                        default: begin
                            n_nz    = r_mz[CB-1] ? quot_neg : quot;
                            n_state = S_WRITE;
                        end
                    endcase
                end
            end
            S_WRITE: begin
                vtx_we       = 1'b1;
                edge_we      = 1'b1;
                n_mid[r_e]   = r_cnt[VIDX-1:0];
                n_cnt        = r_cnt + 1'b1;
                n_e          = r_e + 1'b1;
                n_res        = '0;
                n_res.kind   = RK_VERTEX;
                n_res.ia     = IDX_W'(r_cnt);
                n_res.x      = PORT_CW'(r_nx);
                n_res.y      = PORT_CW'(r_ny);
                n_res.z      = PORT_CW'(r_nz);
                n_res.status = STS_OK;
                n_after      = S_EDGE;
                n_state      = S_EMIT;
            end
            S_TRI: begin
                n_res      = '0;
                n_res.kind = RK_TRI;
                unique case (r_t)
                    2'd0: begin
                        n_res.ia = r_ia;
                        n_res.ib = IDX_W'(r_mid[0]);
                        n_res.ic = IDX_W'(r_mid[2]);
                    end
                    2'd1: begin
                        n_res.ia = IDX_W'(r_mid[0]);
                        n_res.ib = r_ib;
                        n_res.ic = IDX_W'(r_mid[1]);
                    end
                    2'd2: begin
                        n_res.ia = IDX_W'(r_mid[2]);
                        n_res.ib = IDX_W'(r_mid[1]);
                        n_res.ic = r_ic;
                    end
                    default: begin
                        n_res.ia   = IDX_W'(r_mid[0]);
                        n_res.ib   = IDX_W'(r_mid[1]);
                        n_res.ic   = IDX_W'(r_mid[2]);
                        n_res.last = 1'b1;
                    end
                endcase
                n_t     = r_t + 1'b1;
                n_after = (r_t == 2'd3) ? S_IDLE : S_TRI;
                n_state = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_cnt     <= '0;
            r_clr     <= '0;
            r_clr_ack <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_clr     <= n_clr;
            r_clr_ack <= n_clr_ack;
            if (emit_go) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (emit_go) begin
            r_out <= r_res;
        end
        r_after <= n_after;
        r_res   <= n_res;
        r_ia    <= n_ia;
        r_ib    <= n_ib;
        r_ic    <= n_ic;
        r_e     <= n_e;
        r_mid   <= n_mid;
        r_home  <= n_home;
        r_probe <= n_probe;
        r_slot  <= n_slot;
        r_pd    <= n_pd;
        r_mx    <= n_mx;
        r_my    <= n_my;
        r_mz    <= n_mz;
        r_s     <= n_s;
        r_nx    <= n_nx;
        r_ny    <= n_ny;
        r_nz    <= n_nz;
        r_ph    <= n_ph;
        r_t     <= n_t;
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {1'b0, r_out.status, r_out.z, r_out.y, r_out.x,
                            r_out.ic, r_out.ib, r_out.ia};
    assign m_axis_tuser  = r_out.kind;
    assign m_axis_tlast  = r_out.last;

    `EMTS_ASSERT_IMP(a_vtx_wr_room, i_clk, i_rst_n, vtx_we, 32'(r_cnt) < VERTEX_DEPTH)
    `EMTS_ASSERT_IMP(a_arith_idle, i_clk, i_rst_n, arith_req.start, !arith_rsp.busy)
    `EMTS_ASSERT_IMP(a_edge_wr_valid, i_clk, i_rst_n, edge_we && (r_state != S_CLEAR), edge_wdata[EWD-1])
    `EMTS_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, in_xfer, r_state != S_IDLE)

endmodule

// File: src/emts_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module emts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: src/emts_arith.sv
// Shared iterative arithmetic unit: shift-add multiply, digit-by-digit square
// root and restoring division, one step per cycle. Uses emts_pkg.
`timescale 1ns / 1ps

module emts_arith (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  emts_pkg::t_arith_req i_req,
    output emts_pkg::t_arith_rsp o_rsp
);

    import emts_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    t_arith_op           r_op, n_op;
    logic [STEP_W-1:0]   r_steps, n_steps;
    logic [ARITH_W-1:0]  r_acc, n_acc;
    logic [ARITH_W-1:0]  r_a, n_a;
    logic [ARITH_W-1:0]  r_b, n_b;

    logic [ARITH_W-1:0]  trial;
    logic [ARITH_W-1:0]  rem_sh;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_op    = r_op;
        n_steps = r_steps;
        n_acc   = r_acc;
        n_a     = r_a;
        n_b     = r_b;
        trial   = r_a + r_b;
        rem_sh  = {r_acc[ARITH_W-2:0], r_a[ARITH_W-1]};
        if (i_req.start) begin
            n_busy  = 1'b1;
            n_op    = i_req.op;
            n_steps = i_req.steps;
            n_acc   = i_req.acc;
            n_a     = i_req.a;
            n_b     = i_req.b;
        end else if (r_busy) begin
            unique case (r_op)
                AOP_MUL: begin
                    if (r_b[0]) begin
                        n_acc = trial + (r_acc - r_b);
                        n_acc = r_acc + r_a;
                    end
                    n_a = r_a << 1;
                    n_b = r_b >> 1;
                end
                AOP_SQRT: begin
                    if (r_acc >= trial) begin
                        n_acc = r_acc - trial;
                        n_a   = (r_a >> 1) + r_b;
                    end else begin
                        n_a = r_a >> 1;
                    end
                    n_b = r_b >> 2;
                end
                AOP_DIV: begin
                    if (rem_sh >= r_b) begin
                        n_acc = rem_sh - r_b;
                        n_a   = {r_a[ARITH_W-2:0], 1'b1};
                    end else begin
                        n_acc = rem_sh;
                        n_a   = {r_a[ARITH_W-2:0], 1'b0};
                    end
                end
                default: begin
                    n_a = r_a;
                end
            endcase
            n_steps = r_steps - 1'b1;
            if (r_steps == STEP_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_op    <= n_op;
        r_steps <= n_steps;
        r_acc   <= n_acc;
        r_a     <= n_a;
        r_b     <= n_b;
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = (r_op == AOP_MUL) ? r_acc : r_a;

endmodule
